// File: src/nts_pkg.sv
// nts_pkg: shared types and constants of the nearest timestamp matcher
// item and match payload structs, operation codes, gap unit result
// no dependencies
`timescale 1ns / 1ps

package nts_pkg;

	localparam int STAMP_W = 64;
	localparam int TOL_W   = 63;

	localparam logic [TOL_W-1:0] TOL_RESET = 63'd10000000;

	// operation codes of an input request
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [STAMP_W-1:0] stamp;
	} item_t;

	typedef struct packed {
		logic [STAMP_W-1:0] query_stamp;
		logic [STAMP_W-1:0] matched_stamp;
	} match_t;

	// result of the shared gap unit
	typedef struct packed {
		logic               ref_below;
		logic [STAMP_W-1:0] gap;
	} gap_res_t;

endpackage

// File: src/nts_ref_mem.sv
// nts_ref_mem: reference timestamp store, one write and one registered read port
// depends on nts_pkg for the stamp width
`timescale 1ns / 1ps

module nts_ref_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [nts_pkg::STAMP_W-1:0] wr_data,
	input  logic [AW-1:0]              rd_addr,
	output logic [nts_pkg::STAMP_W-1:0] rd_data
);

	logic [nts_pkg::STAMP_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// File: src/nts_gap_unit.sv
// nts_gap_unit: shared subtract unit, absolute gap and order of reference vs query
// depends on nts_pkg for gap_res_t
`timescale 1ns / 1ps

module nts_gap_unit (
	input  logic [nts_pkg::STAMP_W-1:0] query,
	input  logic [nts_pkg::STAMP_W-1:0] ref_stamp,
	output nts_pkg::gap_res_t           res
);

	logic [nts_pkg::STAMP_W:0]   diff;
	logic [nts_pkg::STAMP_W-1:0] rdiff;

	// query minus reference, borrow means reference is later
	always_comb begin
		diff          = {1'b0, query} - {1'b0, ref_stamp};
		rdiff         = ref_stamp - query;
		res.gap       = diff[nts_pkg::STAMP_W] ? rdiff : diff[nts_pkg::STAMP_W-1:0];
		res.ref_below = !diff[nts_pkg::STAMP_W] && (diff[nts_pkg::STAMP_W-1:0] != '0);
	end

endmodule

// File: src/nearest_timestamp_matcher.sv
// nearest_timestamp_matcher: load, clear and query of a reference timestamp store
// load, clear and unused codes are taken in the idle state; a query scans the pointer forward
// and then reads the current, next and previous candidates, since every store entry comes
// through one read port and one shared gap unit; a held match adds its wait; an empty store gives no match
// arst_n clears count, pointer, tolerance (to 10000000) and the output valid flag;
// the store itself is not cleared
`timescale 1ns / 1ps

module nearest_timestamp_matcher #(
	parameter int STORE_DEPTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  nts_pkg::item_t  item,
	output logic            match_valid,
	input  logic            match_ready,
	output nts_pkg::match_t match,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [nts_pkg::TOL_W-1:0] cfg_data
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int SW = CW + 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_CUR  = 6'b000100,
		S_NXT  = 6'b001000,
		S_PRV  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t                      state_q, state_d;
	logic [AW-1:0]               ptr_q, ptr_d;
	logic [CW-1:0]               cnt_q, cnt_d;
	logic [nts_pkg::STAMP_W-1:0] t_q, t_d;
	logic [nts_pkg::STAMP_W-1:0] best_q, best_d;
	logic [nts_pkg::STAMP_W-1:0] best_dt_q, best_dt_d;
	logic [nts_pkg::TOL_W-1:0]   tol_q;
	logic                        match_valid_q;
	nts_pkg::match_t             match_q;
	logic                        load_out;

	logic                        wr_en;
	logic [AW-1:0]               rd_addr;
	logic [nts_pkg::STAMP_W-1:0] rd_data;
	nts_pkg::gap_res_t           gres;

	logic                        accept;
	logic [AW-1:0]               p_start;
	logic [SW-1:0]               ptr_w, cnt_w, p_start_w;

	nts_ref_mem #(
		.DEPTH(STORE_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(cnt_q[AW-1:0]),
		.wr_data(item.stamp),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	nts_gap_unit u_gap (
		.query    (t_q),
		.ref_stamp(rd_data),
		.res      (gres)
	);

	assign item_ready  = (state_q == S_IDLE);
	assign accept      = item_valid && item_ready;
	assign cfg_ready   = 1'b1;
	assign match_valid = match_valid_q;
	assign match       = match_q;

	assign ptr_w     = SW'(ptr_q);
	assign cnt_w     = SW'(cnt_q);
	assign p_start   = (ptr_w >= cnt_w) ? '0 : ptr_q;
	assign p_start_w = SW'(p_start);

	assign wr_en = accept && (item.operation == nts_pkg::OP_LOAD)
		&& (cnt_w < SW'(STORE_DEPTH));

	// sequencer: pointer scan, then current, next and previous candidates
	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		cnt_d     = cnt_q;
		t_d       = t_q;
		best_d    = best_q;
		best_dt_d = best_dt_q;
		rd_addr   = ptr_q;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (item.operation)
						nts_pkg::OP_LOAD: begin
							if (wr_en) begin
								cnt_d = cnt_q + CW'(1);
							end
						end
						nts_pkg::OP_CLEAR: begin
							cnt_d = '0;
							ptr_d = '0;
						end
						nts_pkg::OP_QUERY: begin
							if (cnt_q != '0) begin
								ptr_d = p_start;
								t_d   = item.stamp;
								if (p_start_w + SW'(1) < cnt_w) begin
									rd_addr = p_start + AW'(1);
									state_d = S_SCAN;
								end else begin
									rd_addr = p_start;
									state_d = S_CUR;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				// rd_data holds the entry after the pointer
				if (gres.ref_below) begin
					ptr_d = ptr_q + AW'(1);
					if (ptr_w + SW'(2) < cnt_w) begin
						rd_addr = ptr_q + AW'(2);
					end else begin
						rd_addr = ptr_q + AW'(1);
						state_d = S_CUR;
					end
				end else begin
					rd_addr = ptr_q;
					state_d = S_CUR;
				end
			end
			S_CUR: begin
				best_d    = rd_data;
				best_dt_d = gres.gap;
				if (ptr_w + SW'(1) < cnt_w) begin
					rd_addr = ptr_q + AW'(1);
					state_d = S_NXT;
				end else if (ptr_q != '0) begin
					rd_addr = ptr_q - AW'(1);
					state_d = S_PRV;
				end else begin
					state_d = S_FIN;
				end
			end
			S_NXT: begin
				if (gres.gap < best_dt_q) begin
					best_d    = rd_data;
					best_dt_d = gres.gap;
				end
				if (ptr_q != '0) begin
					rd_addr = ptr_q - AW'(1);
					state_d = S_PRV;
				end else begin
					state_d = S_FIN;
				end
			end
			S_PRV: begin
				if (gres.gap < best_dt_q) begin
					best_d    = rd_data;
					best_dt_d = gres.gap;
				end
				state_d = S_FIN;
			end
			S_FIN: begin
				// tolerance check, wait for a free output register
				if (best_dt_q <= {1'b0, tol_q}) begin
					if (!match_valid_q || match_ready) begin
						load_out = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ptr_q         <= '0;
			cnt_q         <= '0;
			tol_q         <= nts_pkg::TOL_RESET;
			match_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			cnt_q   <= cnt_d;
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			if (load_out) begin
				match_valid_q <= 1'b1;
			end else if (match_ready) begin
				match_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		t_q       <= t_d;
		best_q    <= best_d;
		best_dt_q <= best_dt_d;
		if (load_out) begin
			match_q.query_stamp   <= t_q;
			match_q.matched_stamp <= best_q;
		end
	end

endmodule
